// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands with clock and synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plmr_pkg
// Types and character codes shared by the length modifier rewriter.
// ----------------------------------------------------------------------------
package plmr_pkg;

    localparam logic [15:0] LIMIT_RESET = 16'd2047;

    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_Z     = 8'h7A;
    localparam logic [7:0] C_T     = 8'h74;
    localparam logic [7:0] C_J     = 8'h6A;
    localparam logic [7:0] C_H     = 8'h68;
    localparam logic [7:0] C_LO_L  = 8'h6C;
    localparam logic [7:0] C_UP_L  = 8'h4C;
    localparam logic [7:0] C_Q     = 8'h71;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [10:0] {
        PH_TEXT  = 11'b000_0000_0001,
        PH_PCT   = 11'b000_0000_0010,
        PH_FLAGS = 11'b000_0000_0100,
        PH_WDIG  = 11'b000_0000_1000,
        PH_WSTAR = 11'b000_0001_0000,
        PH_DOT   = 11'b000_0010_0000,
        PH_PDIG  = 11'b000_0100_0000,
        PH_PSTAR = 11'b000_1000_0000,
        PH_HPEND = 11'b001_0000_0000,
        PH_LEN   = 11'b010_0000_0000,
        PH_CONV  = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] count;
        logic        changed;
        logic        stopped;
    } t_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       done_res;
        logic       rewritten;
        logic       truncated;
        logic       last;
    } t_res;

endpackage

// ===== src/plmr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plmr_if
// Valid/ready channels for format requests and rewritten results.
// ----------------------------------------------------------------------------
interface plmr_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

interface plmr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic       rewritten;
    logic       truncated;
    logic       last;

    modport source (output valid, output out_char, output char_valid, output done_res,
                    output rewritten, output truncated, output last, input ready);
    modport sink   (input valid, input out_char, input char_valid, input done_res,
                    input rewritten, input truncated, input last, output ready);
endinterface

// ===== src/plmr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plmr_core
// Next-state and result logic for one request: parse step, limit check,
// up to two results.
// ----------------------------------------------------------------------------
module plmr_core
    import plmr_pkg::*;
(
    input  t_state      i_st,
    input  logic        i_command,
    input  logic [7:0]  i_char,
    input  logic [15:0] i_limit,
    output t_state      o_st,
    output t_res        o_res0,
    output t_res        o_res1,
    output logic [1:0]  o_num
);

    typedef struct packed {
        t_phase     phase;
        logic       e0;
        logic [7:0] c0;
        logic       e1;
        logic [7:0] c1;
        logic       pair;
        logic       chg;
    } t_plan;

    function automatic t_plan f_plan(input t_phase ph, input logic e, input logic [7:0] c);
        t_plan p;
        p.phase = ph;
        p.e0    = e;
        p.c0    = c;
        p.e1    = 1'b0;
        p.c1    = c;
        p.pair  = 1'b0;
        p.chg   = 1'b0;
        return p;
    endfunction

    function automatic logic f_digit(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic f_flag(input logic [7:0] c);
        return (c == C_MINUS) || (c == C_PLUS) || (c == C_SPACE) || (c == C_ZERO)
            || (c == C_HASH);
    endfunction

    function automatic t_plan f_inlen(input logic [7:0] c);
        logic std;
        std = (c == C_H) || (c == C_LO_L) || (c == C_UP_L) || (c == C_Q);
        return f_plan(std ? PH_LEN : PH_TEXT, 1'b1, c);
    endfunction

    function automatic t_plan f_len(input logic [7:0] c);
        t_plan p;
        if (c == C_Z || c == C_T) begin
            p = f_plan(PH_CONV, 1'b0, c);
            p.chg = 1'b1;
        end else if (c == C_J) begin
            p = f_plan(PH_CONV, 1'b1, C_LO_L);
            p.e1   = 1'b1;
            p.c1   = C_LO_L;
            p.pair = 1'b1;
            p.chg  = 1'b1;
        end else if (c == C_H) begin
            p = f_plan(PH_HPEND, 1'b0, c);
        end else begin
            p = f_inlen(c);
        end
        return p;
    endfunction

    function automatic t_plan f_prec(input logic [7:0] c);
        if (c == C_DOT) return f_plan(PH_DOT, 1'b1, c);
        return f_len(c);
    endfunction

    function automatic t_plan f_width(input logic [7:0] c);
        if (c == C_STAR) return f_plan(PH_WSTAR, 1'b1, c);
        if (f_digit(c))  return f_plan(PH_WDIG, 1'b1, c);
        return f_prec(c);
    endfunction

    function automatic t_plan f_flags(input logic [7:0] c);
        if (f_flag(c)) return f_plan(PH_FLAGS, 1'b1, c);
        return f_width(c);
    endfunction

    function automatic t_plan f_take(input t_phase ph, input logic [7:0] c);
        t_plan p;
        case (ph)
            PH_PCT:   p = (c == C_PCT) ? f_plan(PH_TEXT, 1'b1, c) : f_flags(c);
            PH_FLAGS: p = f_flags(c);
            PH_WDIG:  p = f_digit(c) ? f_plan(PH_WDIG, 1'b1, c) : f_prec(c);
            PH_WSTAR: p = f_prec(c);
            PH_DOT: begin
                if (c == C_STAR)     p = f_plan(PH_PSTAR, 1'b1, c);
                else if (f_digit(c)) p = f_plan(PH_PDIG, 1'b1, c);
                else                 p = f_len(c);
            end
            PH_PDIG:  p = f_digit(c) ? f_plan(PH_PDIG, 1'b1, c) : f_len(c);
            PH_PSTAR: p = f_len(c);
            PH_HPEND: begin
                if (c == C_H) begin
                    p = f_plan(PH_CONV, 1'b1, C_H);
                    p.chg = 1'b1;
                end else begin
                    p = f_inlen(c);
                    p.e1 = 1'b1;
                    p.c1 = c;
                    p.e0 = 1'b1;
                    p.c0 = C_H;
                end
            end
            PH_LEN:   p = f_inlen(c);
            PH_CONV:  p = f_plan(PH_TEXT, 1'b1, c);
            default:  p = f_plan((c == C_PCT) ? PH_PCT : PH_TEXT, 1'b1, c);
        endcase
        return p;
    endfunction

    function automatic t_res f_byte(input logic [7:0] c);
        t_res r;
        r.out_char   = c;
        r.char_valid = 1'b1;
        r.done_res   = 1'b0;
        r.rewritten  = 1'b0;
        r.truncated  = 1'b0;
        r.last       = 1'b0;
        return r;
    endfunction

    t_plan plan;
    t_res  status;
    logic  fit1;
    logic  fit2;

    assign fit1 = ({1'b0, i_st.count} + 17'd1) <= {1'b0, i_limit};
    assign fit2 = ({1'b0, i_st.count} + 17'd2) <= {1'b0, i_limit};
    assign plan = f_take(i_st.phase, i_char);

    always_comb begin
        o_st   = i_st;
        o_res0 = f_byte(i_char);
        o_res1 = f_byte(i_char);
        o_num  = 2'd0;
        status = f_byte(8'd0);
        status.char_valid = 1'b0;
        status.done_res   = 1'b1;
        status.rewritten  = i_st.changed;
        status.truncated  = i_st.stopped;
        if (i_command == CMD_END) begin
            if (!i_st.stopped && i_st.phase == PH_HPEND) begin
                if (fit1) begin
                    o_res0 = f_byte(C_H);
                    o_num  = 2'd1;
                end else begin
                    status.truncated = 1'b1;
                end
            end
            if (o_num == 2'd0) o_res0 = status;
            else               o_res1 = status;
            o_num = o_num + 2'd1;
            o_st.phase   = PH_TEXT;
            o_st.count   = 16'd0;
            o_st.changed = 1'b0;
            o_st.stopped = 1'b0;
        end else if (!i_st.stopped) begin
            o_st.phase   = plan.phase;
            o_st.changed = i_st.changed | plan.chg;
            if (plan.pair) begin
                if (fit2) begin
                    o_res0     = f_byte(plan.c0);
                    o_res1     = f_byte(plan.c1);
                    o_num      = 2'd2;
                    o_st.count = i_st.count + 16'd2;
                end else begin
                    o_st.stopped = 1'b1;
                end
            end else if (plan.e0) begin
                if (fit1) begin
                    o_res0     = f_byte(plan.c0);
                    o_num      = 2'd1;
                    o_st.count = i_st.count + 16'd1;
                    if (plan.e1) begin
                        if (fit2) begin
                            o_res1     = f_byte(plan.c1);
                            o_num      = 2'd2;
                            o_st.count = i_st.count + 16'd2;
                        end else begin
                            o_st.stopped = 1'b1;
                        end
                    end
                end else begin
                    o_st.stopped = 1'b1;
                    if (plan.e1) o_st.phase = i_st.phase;
                end
            end
        end
        if (o_num == 2'd1) o_res0.last = 1'b1;
        if (o_num == 2'd2) o_res1.last = 1'b1;
    end

endmodule

// ===== src/printf_length_modifier_rewriter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_length_modifier_rewriter
// Rewrites printf length modifiers in a streamed format string under an
// output limit, and reports changed and truncated status at end of string.
// ----------------------------------------------------------------------------
//  port          dir  handshake     payload
//  i_req         in   valid/ready   command, char_in
//  o_res         out  valid/ready   out_char, char_valid, done_res,
//                                   rewritten, truncated, last
//  i_cfg_*       in   write enable  output_limit (16 bit)
//
//  One request per cycle while ready is high; parse state updates in the cycle it is taken.
//  Each request yields 0 to 2 results into a 4-entry result queue; ready is
//  high while at least 2 slots are free; output drains 1 result a cycle
//  while o_res.ready is high. Results are registered in the queue first.
//  Synchronous active-low reset clears parse state, queue and sets the
//  limit to 2047; ready is held low during reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module printf_length_modifier_rewriter
    import plmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    plmr_req_if.sink    i_req,
    plmr_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_state      r_st;
    t_state      n_st;
    logic [15:0] r_limit;
    t_res        r_q [4];
    logic [1:0]  r_wr;
    logic [1:0]  r_rd;
    logic [2:0]  r_cnt;

    t_res        res0;
    t_res        res1;
    logic [1:0]  res_num;
    logic        accept;
    logic        pop;
    logic [1:0]  push;
    t_res        head;
    logic        stop_take;
    logic        status_out;

    plmr_core u_core (
        .i_st      (r_st),
        .i_command (i_req.command),
        .i_char    (i_req.char_in),
        .i_limit   (r_limit),
        .o_st      (n_st),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_num     (res_num)
    );

    assign i_req.ready = i_rst_n & (r_cnt < 3'd3);
    assign accept      = i_req.valid & i_req.ready;
    assign pop         = o_res.valid & o_res.ready;
    assign push        = accept ? res_num : 2'd0;
    assign head        = r_q[r_rd];

    assign o_res.valid      = (r_cnt != 3'd0);
    assign o_res.out_char   = head.out_char;
    assign o_res.char_valid = head.char_valid;
    assign o_res.done_res   = head.done_res;
    assign o_res.rewritten  = head.rewritten;
    assign o_res.truncated  = head.truncated;
    assign o_res.last       = head.last;

    assign stop_take  = accept & (i_req.command == CMD_CHAR) & r_st.stopped;
    assign status_out = o_res.valid & o_res.done_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase   <= PH_TEXT;
            r_st.count   <= 16'd0;
            r_st.changed <= 1'b0;
            r_st.stopped <= 1'b0;
            r_limit      <= LIMIT_RESET;
            r_wr         <= 2'd0;
            r_rd         <= 2'd0;
            r_cnt        <= 3'd0;
        end else begin
            if (accept) r_st <= n_st;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            r_wr  <= r_wr + push;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) r_q[r_wr] <= res0;
        if (push == 2'd2) r_q[r_wr + 2'd1] <= res1;
    end

    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_cnt <= 3'd4, "result queue overflow")
    `ASSERT_IMPL(a_room, i_clk, i_rst_n, accept, r_cnt <= 3'd2, "request taken without room")
    `ASSERT_NEXT(a_stop_quiet, i_clk, i_rst_n, stop_take, r_cnt <= $past(r_cnt), "output after stop")
    `ASSERT_IMPL(a_status_last, i_clk, i_rst_n, status_out, o_res.last, "status result not last")

endmodule
